FILE: rtl/psu_pkg.sv
// Shared constants, types and filter codes for the PNG scanline unfilter.
// Used by psu_predict and png_scanline_unfilter; depends on nothing.
package psu_pkg;

	localparam int MAX_ROW_BYTES = 8192;
	localparam int MAX_BPP       = 4;
	localparam int COL_W         = $clog2(MAX_ROW_BYTES);
	localparam int ROWB_W        = COL_W + 1;
	localparam int BPP_IDX_W     = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
	localparam int WIN_W         = 8 * MAX_BPP;
	localparam int CFG_W         = 12;

	typedef logic [7:0]        byte_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROWB_W-1:0] rowb_t;

	localparam byte_t FILT_NONE  = 8'd0;
	localparam byte_t FILT_SUB   = 8'd1;
	localparam byte_t FILT_UP    = 8'd2;
	localparam byte_t FILT_AVG   = 8'd3;
	localparam byte_t FILT_PAETH = 8'd4;

	localparam logic REG_ROW_PIXELS = 1'b0;
	localparam logic REG_BPP        = 1'b1;

	// one word in the reconstruct stage
	typedef struct packed {
		logic  is_data;   // 0: filter-type word, clears the windows
		logic  first_row;
		logic  last;
		byte_t filter;
		byte_t x;
		col_t  col;
	} s1_t;

endpackage

FILE: rtl/png_scanline_unfilter.sv
// PNG scanline unfilter, top level: filter-type byte handling, column
// tracking, previous-row memory and output register. Depends on psu_pkg,
// psu_ram and psu_predict.
//
// Takes one filtered byte per cycle and gives one rebuilt byte per data
// byte, sustained at one word per clock with no gaps between rows while
// the output is not stalled. The previous-row memory read is registered;
// reconstruction fills the output register. Filter-type bytes give no output.
// The previous row is held in one 8192 x 8 memory that is read at the current
// column and written back with the rebuilt byte by the next stage; it has no
// clearing pass, so entries beyond the last row's width read as garbage.
// Write the registers only while the block is idle.
module png_scanline_unfilter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [psu_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,   // in_byte
	input  logic                        s_axis_tuser,   // image_start
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,   // out_byte
	output logic                        m_axis_tlast    // row_last
);
	import psu_pkg::*;

	logic [11:0]          row_pixels_q;
	logic [2:0]           bpp_cfg_q;
	logic [2:0]           bpp_eff;
	logic [BPP_IDX_W-1:0] bpp_idx;
	logic [11:0]          pix_eff;
	logic [14:0]          prod;
	rowb_t                row_bytes;

	col_t                 col_q;
	byte_t                filter_q;
	logic                 first_row_q;
	logic                 expect_q;

	logic                 en;
	logic                 accept;
	logic                 take_filter;
	col_t                 col_cur;
	rowb_t                col_next;
	logic                 last_cur;

	s1_t                  s1_d, item_s1;
	logic                 valid_s1;

	logic [WIN_W-1:0]     left_q, upleft_q;
	byte_t                ram_rdata;
	byte_t                a, b, c, r;

	logic                 out_valid_q;
	byte_t                out_byte_q;
	logic                 out_last_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pixels_q <= 12'd1;
			bpp_cfg_q    <= 3'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_PIXELS: row_pixels_q <= cfg_data[11:0];
				REG_BPP:        bpp_cfg_q    <= cfg_data[2:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		if (bpp_cfg_q == 3'd0) begin
			bpp_eff = 3'd1;
		end else if (32'(bpp_cfg_q) > MAX_BPP) begin
			bpp_eff = 3'(MAX_BPP);
		end else begin
			bpp_eff = bpp_cfg_q;
		end
		bpp_idx = BPP_IDX_W'(bpp_eff - 3'd1);
		pix_eff = (row_pixels_q == 12'd0) ? 12'd1 : row_pixels_q;
		prod    = 15'(pix_eff) * 15'(bpp_eff);
		if (32'(prod) > MAX_ROW_BYTES) begin
			row_bytes = ROWB_W'(MAX_ROW_BYTES);
		end else begin
			row_bytes = ROWB_W'(prod);
		end
	end

	// accept side
	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;
	assign take_filter   = s_axis_tuser || expect_q;

	always_comb begin
		if ({1'b0, col_q} >= row_bytes) begin
			col_cur = COL_W'(row_bytes - rowb_t'(1));
		end else begin
			col_cur = col_q;
		end
		col_next = {1'b0, col_cur} + rowb_t'(1);
		last_cur = col_next >= row_bytes;

		s1_d.is_data   = !take_filter;
		s1_d.first_row = first_row_q;
		s1_d.last      = last_cur;
		s1_d.filter    = filter_q;
		s1_d.x         = s_axis_tdata;
		s1_d.col       = col_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			filter_q    <= FILT_NONE;
			first_row_q <= 1'b1;
			expect_q    <= 1'b1;
		end else if (accept) begin
			if (take_filter) begin
				filter_q <= s_axis_tdata;
				col_q    <= '0;
				expect_q <= 1'b0;
				if (s_axis_tuser) begin
					first_row_q <= 1'b1;
				end
			end else if (last_cur) begin
				col_q       <= '0;
				expect_q    <= 1'b1;
				first_row_q <= 1'b0;
			end else begin
				col_q <= COL_W'(col_next);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= s1_d;
		end
	end

	// previous row, read at accept, written back in the reconstruct stage
	psu_ram #(
		.WIDTH(8),
		.DEPTH(MAX_ROW_BYTES)
	) u_prior_row (
		.clk  (clk),
		.we   (en && valid_s1 && item_s1.is_data),
		.waddr(item_s1.col),
		.wdata(r),
		.re   (accept && !take_filter),
		.raddr(col_cur),
		.rdata(ram_rdata)
	);

	// reconstruct stage
	assign a = left_q[8*bpp_idx +: 8];
	assign b = item_s1.first_row ? 8'd0 : ram_rdata;
	assign c = item_s1.first_row ? 8'd0 : upleft_q[8*bpp_idx +: 8];

	psu_predict u_predict (
		.filter(item_s1.filter),
		.x     (item_s1.x),
		.a     (a),
		.b     (b),
		.c     (c),
		.r     (r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (en && valid_s1) begin
			if (item_s1.is_data) begin
				left_q   <= {left_q[WIN_W-9:0], r};
				upleft_q <= {upleft_q[WIN_W-9:0], b};
			end else begin
				left_q   <= '0;
				upleft_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s1 && item_s1.is_data;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_byte_q <= r;
			out_last_q <= item_s1.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/psu_ram.sv
// Generic simple dual-port RAM, one write port, one read port, registered read.
// No dependencies.
module psu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/psu_predict.sv
// Filter reconstruction: None, Sub, Up, Average, Paeth, modulo 256.
// Depends on psu_pkg.
module psu_predict (
	input  psu_pkg::byte_t filter,
	input  psu_pkg::byte_t x,
	input  psu_pkg::byte_t a,
	input  psu_pkg::byte_t b,
	input  psu_pkg::byte_t c,
	output psu_pkg::byte_t r
);
	import psu_pkg::*;

	logic signed [10:0] pa_d, pb_d, pc_d;
	logic        [9:0]  pa, pb, pc;
	byte_t              paeth;
	logic        [8:0]  avg_sum;
	byte_t              pred;

	always_comb begin
		// pa = |b-c|, pb = |a-c|, pc = |a+b-2c|
		pa_d = $signed({3'b000, b}) - $signed({3'b000, c});
		pb_d = $signed({3'b000, a}) - $signed({3'b000, c});
		pc_d = pa_d + pb_d;
		pa = pa_d[10] ? 10'(-pa_d) : pa_d[9:0];
		pb = pb_d[10] ? 10'(-pb_d) : pb_d[9:0];
		pc = pc_d[10] ? 10'(-pc_d) : pc_d[9:0];
		if (pa <= pb && pa <= pc) begin
			paeth = a;
		end else if (pb <= pc) begin
			paeth = b;
		end else begin
			paeth = c;
		end
		avg_sum = {1'b0, a} + {1'b0, b};
	end

	always_comb begin
		unique case (filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth;
			default:    pred = 8'd0;
		endcase
	end

	assign r = x + pred;

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for png_scanline_unfilter: directed rows for every filter,
// then random images. Predicts each rebuilt byte and compares it on the output.
// Depends on psu_pkg and the png_scanline_unfilter RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psu_pkg::*;

	localparam int    LATENCY      = 2;
	localparam int    RANDOM_WORDS = 1700;
	localparam int    CYCLE_LIMIT  = 1000000;
	localparam byte_t FILT_ODD     = 8'hFF;

	typedef struct {
		byte_t data;
		logic  start;
	} filtered_t;

	typedef struct {
		byte_t data;
		logic  last;
	} rebuilt_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;   // in_byte
	logic              s_axis_tuser = 1'b0; // image_start
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;        // out_byte
	logic              m_axis_tlast;        // row_last

	png_scanline_unfilter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	filtered_t filtered_q [$];
	rebuilt_t  rebuilt_q [$];
	int        words_pending = 0;
	int        words_sent = 0;
	int        errors = 0;
	int        cycles = 0;
	int        src_mode = 0;
	int        snk_mode = 0;
	int        gap_left = 0;
	int        hold_left = 0;
	logic      in_taken = 1'b0;
	logic      out_taken = 1'b0;
	int        gen_pix = 1;
	int        gen_bpp = 1;

	// shadow of the unfilter state
	byte_t            up_row [MAX_ROW_BYTES];
	logic [WIN_W-1:0] left_win = '0;
	logic [WIN_W-1:0] upleft_win = '0;
	int               col = 0;
	byte_t            cur_filt = FILT_NONE;
	logic             first_row = 1'b1;
	logic             want_filter = 1'b1;
	logic [11:0]      row_pix = 12'd1;
	logic [2:0]       pix_bytes = 3'd1;

	function automatic int eff_bpp(int bpp);
		if (bpp == 0)
			return 1;
		return (bpp > MAX_BPP) ? MAX_BPP : bpp;
	endfunction

	function automatic int row_len(int pix, int bpp);
		int n;
		n = ((pix == 0) ? 1 : pix) * eff_bpp(bpp);
		return (n > MAX_ROW_BYTES) ? MAX_ROW_BYTES : n;
	endfunction

	function automatic int paeth(int a, int b, int c);
		int p, pa, pb, pc;
		p = a + b - c;
		pa = (p > a) ? p - a : a - p;
		pb = (p > b) ? p - b : b - p;
		pc = (p > c) ? p - c : c - p;
		if (pa <= pb && pa <= pc)
			return a;
		if (pb <= pc)
			return b;
		return c;
	endfunction

	function automatic logic unfilter_byte(input byte_t x, input logic start,
			output rebuilt_t res);
		int bpp, rb, a, b, c, pred;
		res.data = '0;
		res.last = 1'b0;
		if (start) begin
			first_row = 1'b1;
			want_filter = 1'b1;
		end
		if (want_filter) begin
			cur_filt = x;
			col = 0;
			left_win = '0;
			upleft_win = '0;
			want_filter = 1'b0;
			return 1'b0;
		end
		bpp = eff_bpp(int'(pix_bytes));
		rb = row_len(int'(row_pix), int'(pix_bytes));
		if (col >= rb)
			col = rb - 1;
		a = int'((left_win >> (8 * (bpp - 1))) & 32'hFF);
		c = first_row ? 0 : int'((upleft_win >> (8 * (bpp - 1))) & 32'hFF);
		b = first_row ? 0 : int'(up_row[col[COL_W-1:0]]);
		case (cur_filt)
			FILT_NONE:  pred = 0;
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = (a + b) >> 1;
			FILT_PAETH: pred = paeth(a, b, c);
			default:    pred = 0;
		endcase
		res.data = x + pred[7:0];
		up_row[col[COL_W-1:0]] = res.data;
		left_win = {left_win[WIN_W-9:0], res.data};
		upleft_win = {upleft_win[WIN_W-9:0], b[7:0]};
		col++;
		res.last = (col >= rb);
		if (res.last) begin
			col = 0;
			want_filter = 1'b1;
			first_row = 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic int draw_wait(int mode);
		case (mode)
			0:       return 0;
			1:       return $urandom_range(0, 19);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
		endcase
	endfunction

	always @(negedge clk) begin
		filtered_t w;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_taken) begin
			if (gap_left > 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left--;
			end else if (filtered_q.size() != 0) begin
				w = filtered_q.pop_front();
				s_axis_tdata <= w.data;
				s_axis_tuser <= w.start;
				s_axis_tvalid <= 1'b1;
				gap_left = draw_wait(src_mode);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_taken)
			hold_left = draw_wait(snk_mode);
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rebuilt_t res, want;
		in_taken <= s_axis_tvalid && s_axis_tready;
		out_taken <= m_axis_tvalid && m_axis_tready;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_ROW_PIXELS)
					row_pix = cfg_data;
				else
					pix_bytes = cfg_data[2:0];
			end
			if (s_axis_tvalid && s_axis_tready) begin
				words_pending--;
				if (unfilter_byte(s_axis_tdata, s_axis_tuser, res))
					rebuilt_q.push_back(res);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (rebuilt_q.size() == 0) begin
					errors++;
					$display("%0t unexpected word: expected none, got %02h last %b",
						$time, m_axis_tdata, m_axis_tlast);
				end else begin
					want = rebuilt_q.pop_front();
					if (m_axis_tdata !== want.data) begin
						errors++;
						$display("%0t out_byte: expected %02h, got %02h",
							$time, want.data, m_axis_tdata);
					end
					if (m_axis_tlast !== want.last) begin
						errors++;
						$display("%0t row_last: expected %b, got %b",
							$time, want.last, m_axis_tlast);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic push_word(input byte_t x, input logic start);
		filtered_q.push_back('{data: x, start: start});
		words_pending++;
		words_sent++;
	endtask

	// wait until every word is taken and every rebuilt byte has come out
	task automatic settle();
		while (words_pending != 0 || rebuilt_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input int val);
		settle();
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROW_PIXELS)
			gen_pix = val & 32'hFFF;
		else
			gen_bpp = val & 32'h7;
	endtask

	function automatic byte_t pick_filter();
		if ($urandom_range(0, 9) == 0)
			return byte_t'($urandom_range(FILT_PAETH + 1, 255));
		return byte_t'($urandom_range(FILT_NONE, FILT_PAETH));
	endfunction

	// rows of one image; a broken image may stop mid-row or restart early
	task automatic push_image(input int rows, input logic broken);
		int rb, cut;
		rb = row_len(gen_pix, gen_bpp);
		for (int r = 0; r < rows; r++) begin
			push_word(pick_filter(), r == 0 || (broken && $urandom_range(0, 7) == 0));
			cut = rb;
			if (broken && $urandom_range(0, 3) == 0)
				cut = $urandom_range(0, rb - 1);
			for (int i = 0; i < cut; i++)
				push_word(byte_t'($urandom_range(0, 255)),
					broken && $urandom_range(0, 39) == 0);
			if (cut < rb)
				break;
		end
	endtask

	initial begin
		byte_t dir_filt [7];
		int    goal;
		int    sel;
		dir_filt = '{FILT_PAETH, FILT_SUB, FILT_UP, FILT_AVG, FILT_PAETH, FILT_ODD,
			FILT_NONE};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// every filter on two-byte rows of extreme values
		src_mode = 0;
		snk_mode = 1;
		write_reg(REG_ROW_PIXELS, 2);
		write_reg(REG_BPP, 1);
		for (int i = 0; i < 7; i++) begin
			push_word(dir_filt[i], i == 0);
			push_word(8'hFF, 1'b0);
			push_word(8'h00, 1'b0);
		end
		// average on a first row, then a new image cutting a row short
		push_word(FILT_AVG, 1'b1);
		push_word(8'hC9, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(FILT_PAETH, 1'b0);
		push_word(8'h07, 1'b0);
		push_word(FILT_UP, 1'b1);
		push_word(8'h80, 1'b0);
		push_word(8'h7F, 1'b0);
		push_word(FILT_SUB, 1'b0);
		push_word(8'h01, 1'b0);
		push_word(8'hFE, 1'b0);

		// zero width, oversized pixel
		src_mode = 2;
		snk_mode = 2;
		write_reg(REG_ROW_PIXELS, 0);
		write_reg(REG_BPP, 7);
		push_image(2, 1'b0);

		// zero pixel size, then the row shrinks under the current column
		write_reg(REG_ROW_PIXELS, 4);
		write_reg(REG_BPP, 0);
		push_word(FILT_SUB, 1'b1);
		repeat (4) push_word(byte_t'($urandom_range(0, 255)), 1'b0);
		push_word(FILT_PAETH, 1'b0);
		repeat (2) push_word(byte_t'($urandom_range(0, 255)), 1'b0);
		write_reg(REG_ROW_PIXELS, 1);
		push_word(byte_t'($urandom_range(0, 255)), 1'b0);
		push_word(FILT_UP, 1'b0);
		push_word(byte_t'($urandom_range(0, 255)), 1'b0);

		// widest row, saturated
		src_mode = 0;
		snk_mode = 0;
		write_reg(REG_ROW_PIXELS, 4095);
		write_reg(REG_BPP, 7);
		push_image(2, 1'b0);
		settle();

		goal = words_sent + RANDOM_WORDS;
		while (words_sent < goal) begin
			sel = $urandom_range(0, 19);
			if (sel < 16)
				write_reg(REG_ROW_PIXELS, $urandom_range(1, 8));
			else if (sel < 19)
				write_reg(REG_ROW_PIXELS, $urandom_range(9, 64));
			else
				write_reg(REG_ROW_PIXELS, $urandom_range(65, 300));
			write_reg(REG_BPP, $urandom_range(0, 7));
			src_mode = $urandom_range(0, 2);
			snk_mode = $urandom_range(0, 2);
			repeat ($urandom_range(1, 3)) begin
				push_image($urandom_range(1, 4), $urandom_range(0, 3) == 0);
				if ($urandom_range(0, 4) == 0)
					settle();
			end
		end

		settle();
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/psu_pkg.sv
rtl/psu_ram.sv
rtl/psu_predict.sv
rtl/png_scanline_unfilter.sv
tb/sv/tb.sv
